/* rtl/core/ppbuf_pkg.sv */
// ppbuf_pkg: shared codes and item layouts for the ping-pong transmit buffer manager
package ppbuf_pkg;

	localparam logic [2:0] ACT_RESERVE  = 3'd0;
	localparam logic [2:0] ACT_WRITE    = 3'd1;
	localparam logic [2:0] ACT_POLL     = 3'd2;
	localparam logic [2:0] ACT_COMPLETE = 3'd3;
	localparam logic [2:0] ACT_READ     = 3'd4;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_NO_BANK = 2'd1;
	localparam logic [1:0] STS_CLASH   = 2'd2;
	localparam logic [1:0] STS_FULL    = 2'd3;

	localparam logic [1:0] BANK_IDLE     = 2'd0;
	localparam logic [1:0] BANK_FILLING  = 2'd1;
	localparam logic [1:0] BANK_CLOSED   = 2'd2;
	localparam logic [1:0] BANK_TRANSMIT = 2'd3;

	localparam logic [1:0] MODE_DATA    = 2'd0;
	localparam logic [1:0] MODE_DONE    = 2'd1;
	localparam logic [1:0] MODE_WRITERS = 2'd2;

	localparam int IN_DATA_BITS  = 48;
	localparam int OUT_DATA_BITS = 40;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [8:0]  byte_address;
		logic        bank_select;
		logic [15:0] task_mask;
		logic [9:0]  packet_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] trigger_state;
		logic [9:0] transmit_length;
		logic       transmit_bank;
		logic       start_transmit;
		logic [8:0] start_index;
		logic [1:0] status;
	} out_item_t;

	localparam int IN_ITEM_BITS  = $bits(in_item_t);
	localparam int OUT_ITEM_BITS = $bits(out_item_t);

endpackage

/* rtl/core/ping_pong_tx_buffer_manager.sv */
// ping_pong_tx_buffer_manager: two-bank transmit buffer with reserve, write, trigger and read
//
// items enter on s_axis: tuser carries the action (reserve, write byte, poll,
// transmit complete, read byte), tlast marks the final byte of a reserved packet
// and tdata the remaining fields. every item returns exactly one result item on
// m_axis, in order.
// an accepted item is held in an input register while the bank flags are
// updated, then lands in the output register that drives m_axis_tvalid, and
// one item is accepted every cycle while m_axis_tready stays high.
// the byte store is a single-port memory written and read when the item is
// accepted, so a read sees every earlier write.
// reset puts bank 0 in filling and bank 1 idle with empty fill indexes, clears
// the writer masks and returns the trigger to waiting for data; the byte store
// is not cleared and must be written before it is read.
// when m_axis_tready is low the result stays in the output register, the item
// behind it waits in the input register and s_axis_tready drops once both are
// full; no item is lost or repeated.
module ping_pong_tx_buffer_manager #(
	parameter int BANK_BYTES  = 512,
	parameter int WRITER_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// packet_length[9:0], task_mask[25:10], bank_select[26], byte_address[35:27],
	// data_byte[43:36], zero pad
	input  logic [ppbuf_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
	// action[2:0]
	input  logic [2:0]                            s_axis_tuser,
	input  logic                                  s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// status[1:0], start_index[10:2], start_transmit[11], transmit_bank[12],
	// transmit_length[22:13], trigger_state[24:23], read_data[32:25], zero pad
	output logic [ppbuf_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

	localparam int FW        = $clog2(BANK_BYTES);
	localparam int MEM_DEPTH = 2 * BANK_BYTES;
	localparam int MW        = $clog2(MEM_DEPTH);
	localparam int SW        = ((FW > 10) ? FW : 10) + 1;

	logic [7:0] mem [0:MEM_DEPTH-1];

	ppbuf_pkg::in_item_t  in_item;
	ppbuf_pkg::in_item_t  item_s1;
	logic [2:0]           action_s1;
	logic                 last_s1;
	logic                 valid_s1;
	logic [7:0]           rdata_s1;
	logic                 rd_hit_s1;

	ppbuf_pkg::out_item_t out_q;
	ppbuf_pkg::out_item_t res;
	logic                 out_valid_q;

	logic [FW-1:0]          fill_q [2];
	logic [FW-1:0]          fill_n [2];
	logic [1:0]             st_q [2];
	logic [1:0]             st_n [2];
	logic [WRITER_BITS-1:0] wm_q [2];
	logic [WRITER_BITS-1:0] wm_n [2];
	logic [1:0]             mode_q;
	logic [1:0]             mode_n;
	logic                   pend_q;
	logic                   pend_n;

	logic                   accept;
	logic                   advance;
	logic [31:0]            addr_ext;
	logic [31:0]            idx_full;
	logic [MW-1:0]          mem_idx;
	logic                   addr_ok;

	logic                   f_found;
	logic                   fb;
	logic                   c_found;
	logic                   cb;
	logic                   t_found;
	logic                   tb;
	logic [WRITER_BITS-1:0] mask_s1;
	logic [SW-1:0]          sum;
	logic [31:0]            fill_ext;
	logic                   start_bank;
	logic                   do_start;

	assign in_item       = ppbuf_pkg::in_item_t'(s_axis_tdata[ppbuf_pkg::IN_ITEM_BITS-1:0]);
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// byte store addressing, done at acceptance
	assign addr_ext = 32'(in_item.byte_address);
	assign addr_ok  = addr_ext < 32'(BANK_BYTES);
	assign idx_full = (in_item.bank_select ? 32'(BANK_BYTES) : 32'd0) + addr_ext;
	assign mem_idx  = idx_full[MW-1:0];

	always_ff @(posedge clk) begin
		if (accept && addr_ok) begin
			if (s_axis_tuser == ppbuf_pkg::ACT_WRITE) begin
				mem[mem_idx] <= in_item.data_byte;
			end
			if (s_axis_tuser == ppbuf_pkg::ACT_READ) begin
				rdata_s1 <= mem[mem_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1   <= in_item;
			action_s1 <= s_axis_tuser;
			last_s1   <= s_axis_tlast;
			rd_hit_s1 <= (s_axis_tuser == ppbuf_pkg::ACT_READ) && addr_ok;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	// bank searches, bank 0 first
	assign f_found = (st_q[0] == ppbuf_pkg::BANK_FILLING) || (st_q[1] == ppbuf_pkg::BANK_FILLING);
	assign fb      = (st_q[0] != ppbuf_pkg::BANK_FILLING);
	assign c_found = (st_q[0] == ppbuf_pkg::BANK_CLOSED) || (st_q[1] == ppbuf_pkg::BANK_CLOSED);
	assign cb      = (st_q[0] != ppbuf_pkg::BANK_CLOSED);
	assign t_found = (st_q[0] == ppbuf_pkg::BANK_TRANSMIT) ||
	                 (st_q[1] == ppbuf_pkg::BANK_TRANSMIT);
	assign tb      = (st_q[0] != ppbuf_pkg::BANK_TRANSMIT);
	assign mask_s1 = item_s1.task_mask[WRITER_BITS-1:0];
	assign sum     = SW'(fill_q[fb]) + SW'(item_s1.packet_length);

	always_comb begin
		fill_n     = fill_q;
		st_n       = st_q;
		wm_n       = wm_q;
		mode_n     = mode_q;
		pend_n     = pend_q;
		res        = '0;
		start_bank = 1'b0;
		do_start   = 1'b0;
		case (action_s1)
			ppbuf_pkg::ACT_RESERVE: begin
				if (!f_found) begin
					res.status = ppbuf_pkg::STS_NO_BANK;
				end else if ((wm_q[fb] & mask_s1) != '0) begin
					res.status = ppbuf_pkg::STS_CLASH;
				end else if (sum < SW'(BANK_BYTES)) begin
					fill_ext        = 32'(fill_q[fb]);
					res.start_index = fill_ext[8:0];
					fill_n[fb]      = FW'(sum);
					wm_n[fb]        = wm_q[fb] | mask_s1;
				end else begin
					res.status = ppbuf_pkg::STS_FULL;
				end
			end
			ppbuf_pkg::ACT_WRITE: begin
				if (last_s1) begin
					wm_n[item_s1.bank_select] = wm_q[item_s1.bank_select] & ~mask_s1;
				end
			end
			ppbuf_pkg::ACT_POLL: begin
				unique case (mode_q)
					ppbuf_pkg::MODE_DATA: begin
						if (f_found && fill_q[fb] != '0) begin
							st_n[fb]   = ppbuf_pkg::BANK_CLOSED;
							st_n[!fb]  = ppbuf_pkg::BANK_FILLING;
							fill_n[!fb] = '0;
							start_bank = fb;
							do_start   = 1'b1;
						end
					end
					ppbuf_pkg::MODE_DONE: begin
						if (pend_q) begin
							pend_n = 1'b0;
							if (t_found) begin
								st_n[tb] = ppbuf_pkg::BANK_IDLE;
							end
							mode_n = ppbuf_pkg::MODE_DATA;
						end
					end
					default: begin
						if (c_found) begin
							start_bank = cb;
							do_start   = 1'b1;
						end
					end
				endcase
				if (do_start) begin
					if (wm_q[start_bank] == '0) begin
						st_n[start_bank]    = ppbuf_pkg::BANK_TRANSMIT;
						mode_n              = ppbuf_pkg::MODE_DONE;
						fill_ext            = 32'(fill_q[start_bank]);
						res.start_transmit  = 1'b1;
						res.transmit_bank   = start_bank;
						res.transmit_length = fill_ext[9:0];
					end else begin
						mode_n = ppbuf_pkg::MODE_WRITERS;
					end
				end
			end
			ppbuf_pkg::ACT_COMPLETE: begin
				pend_n = 1'b1;
			end
			default: begin
			end
		endcase
		fill_ext          = 32'(fill_q[start_bank]);
		res.trigger_state = mode_n;
		res.read_data     = rd_hit_s1 ? rdata_s1 : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			st_q[0]     <= ppbuf_pkg::BANK_FILLING;
			st_q[1]     <= ppbuf_pkg::BANK_IDLE;
			wm_q[0]     <= '0;
			wm_q[1]     <= '0;
			mode_q      <= ppbuf_pkg::MODE_DATA;
			pend_q      <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				fill_q      <= fill_n;
				st_q        <= st_n;
				wm_q        <= wm_n;
				mode_q      <= mode_n;
				pend_q      <= pend_n;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(ppbuf_pkg::OUT_DATA_BITS - ppbuf_pkg::OUT_ITEM_BITS)'(0), out_q};

endmodule

/* verif/tb.sv */
// tb: self-checking stream testbench for the ping-pong transmit buffer manager
`timescale 1ns / 1ps

module tb;

	localparam int BANK_BYTES  = 512;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]          act;
		logic                last;
		ppbuf_pkg::in_item_t f;
	} stim_t;

	typedef struct packed {
		logic [2*BANK_BYTES-1:0][7:0] mem;
		logic [1:0][1:0]              bstat;
		logic [1:0][9:0]              fill;
		logic [1:0][15:0]             wmask;
		logic [1:0]                   mode;
		logic                         pend;
	} buf_state_t;

	logic                                s_axis_tvalid = 1'b0;
	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tready;
	logic [ppbuf_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
	logic [2:0]                          s_axis_tuser;
	logic                                s_axis_tlast;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [ppbuf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

	stim_t                cur_item = '0;
	stim_t                pending_items[$];
	ppbuf_pkg::out_item_t expected_results[$];
	int                   written_q[$];
	buf_state_t           plan_state;
	buf_state_t           dut_view;
	bit                   took = 1'b0;
	int                   send_idle = 0;
	int                   recv_idle = 0;
	int                   quiet_cycles = 0;
	int                   errors = 0;
	int                   planned = 0;

	assign s_axis_tdata = ppbuf_pkg::IN_DATA_BITS'(cur_item.f);
	assign s_axis_tuser = cur_item.act;
	assign s_axis_tlast = cur_item.last;

	ping_pong_tx_buffer_manager #(
		.BANK_BYTES(BANK_BYTES),
		.WRITER_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic buf_state_t reset_state();
		buf_state_t s;
		s = '0;
		s.bstat[0] = ppbuf_pkg::BANK_FILLING;
		s.bstat[1] = ppbuf_pkg::BANK_IDLE;
		s.mode = ppbuf_pkg::MODE_DATA;
		return s;
	endfunction

	function automatic int find_bank(logic [1:0][1:0] bst, logic [1:0] st);
		if (bst[0] == st) return 0;
		if (bst[1] == st) return 1;
		return -1;
	endfunction

	task automatic advance_buffer(inout buf_state_t s, input stim_t it,
			output ppbuf_pkg::out_item_t r);
		int b;
		int tx;
		tx = -1;
		r = '0;
		case (it.act)
			ppbuf_pkg::ACT_RESERVE: begin
				b = find_bank(s.bstat, ppbuf_pkg::BANK_FILLING);
				if (b < 0) begin
					r.status = ppbuf_pkg::STS_NO_BANK;
				end else if ((s.wmask[b] & it.f.task_mask) != 16'd0) begin
					r.status = ppbuf_pkg::STS_CLASH;
				end else if (int'(s.fill[b]) < BANK_BYTES &&
						int'(it.f.packet_length) < BANK_BYTES - int'(s.fill[b])) begin
					r.start_index = s.fill[b][8:0];
					s.fill[b] = s.fill[b] + it.f.packet_length;
					s.wmask[b] = s.wmask[b] | it.f.task_mask;
				end else begin
					r.status = ppbuf_pkg::STS_FULL;
				end
			end
			ppbuf_pkg::ACT_WRITE: begin
				s.mem[{it.f.bank_select, it.f.byte_address}] = it.f.data_byte;
				if (it.last)
					s.wmask[it.f.bank_select] = s.wmask[it.f.bank_select] & ~it.f.task_mask;
			end
			ppbuf_pkg::ACT_POLL: begin
				if (s.mode == ppbuf_pkg::MODE_DATA) begin
					b = find_bank(s.bstat, ppbuf_pkg::BANK_FILLING);
					if (b >= 0 && s.fill[b] != 10'd0) begin
						s.bstat[b] = ppbuf_pkg::BANK_CLOSED;
						s.bstat[1-b] = ppbuf_pkg::BANK_FILLING;
						s.fill[1-b] = 10'd0;
						tx = b;
					end
				end else if (s.mode == ppbuf_pkg::MODE_DONE) begin
					if (s.pend) begin
						b = find_bank(s.bstat, ppbuf_pkg::BANK_TRANSMIT);
						s.pend = 1'b0;
						if (b >= 0)
							s.bstat[b] = ppbuf_pkg::BANK_IDLE;
						s.mode = ppbuf_pkg::MODE_DATA;
					end
				end else begin
					tx = find_bank(s.bstat, ppbuf_pkg::BANK_CLOSED);
				end
				if (tx >= 0) begin
					if (s.wmask[tx] == 16'd0) begin
						s.bstat[tx] = ppbuf_pkg::BANK_TRANSMIT;
						s.mode = ppbuf_pkg::MODE_DONE;
						r.start_transmit = 1'b1;
						r.transmit_bank = tx[0];
						r.transmit_length = s.fill[tx];
					end else begin
						s.mode = ppbuf_pkg::MODE_WRITERS;
					end
				end
			end
			ppbuf_pkg::ACT_COMPLETE: s.pend = 1'b1;
			ppbuf_pkg::ACT_READ: r.read_data = s.mem[{it.f.bank_select, it.f.byte_address}];
			default: ;
		endcase
		r.trigger_state = s.mode;
	endtask

	task automatic add_item(input logic [2:0] act, input logic [9:0] len,
			input logic [15:0] mask, input logic bank, input logic [8:0] addr,
			input logic [7:0] data, input logic last, output ppbuf_pkg::out_item_t r);
		stim_t it;
		it.act = act;
		it.last = last;
		it.f.packet_length = len;
		it.f.task_mask = mask;
		it.f.bank_select = bank;
		it.f.byte_address = addr;
		it.f.data_byte = data;
		advance_buffer(plan_state, it, r);
		if (act == ppbuf_pkg::ACT_WRITE)
			written_q.push_back(int'({bank, addr}));
		pending_items.push_back(it);
		planned++;
	endtask

	task automatic add_read();
		int idx;
		ppbuf_pkg::out_item_t r;
		idx = written_q[$urandom_range(0, written_q.size() - 1)];
		add_item(ppbuf_pkg::ACT_READ, 10'($urandom_range(0, 512)), 16'($urandom), idx[9],
			idx[8:0], 8'($urandom), 1'($urandom), r);
	endtask

	// well-formed packets with random content, mixed with control items and noise
	task automatic gen_traffic(int n);
		int stop_at;
		int sel;
		int fb;
		int nw;
		int off;
		int base;
		logic [15:0] m;
		logic [9:0] len;
		logic [2:0] act;
		ppbuf_pkg::out_item_t r;
		stop_at = planned + n;
		while (planned < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				m = 16'(1 << $urandom_range(0, 15));
				if ($urandom_range(0, 3) == 0)
					m = m | 16'($urandom);
				if ($urandom_range(0, 19) == 0)
					m = 16'd0;
				len = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 512))
					: 10'($urandom_range(0, 12));
				fb = find_bank(plan_state.bstat, ppbuf_pkg::BANK_FILLING);
				add_item(ppbuf_pkg::ACT_RESERVE, len, m, 1'($urandom), 9'($urandom),
					8'($urandom), 1'($urandom), r);
				if (r.status == ppbuf_pkg::STS_OK && fb >= 0) begin
					base = int'(r.start_index);
					if ($urandom_range(0, 4) == 0)
						add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
					nw = (len == 0) ? 1 : ((len > 6) ? 6 : int'(len));
					for (int i = 0; i < nw; i++) begin
						off = (i == nw - 1) ? ((len == 0) ? 0 : int'(len) - 1) : i;
						add_item(ppbuf_pkg::ACT_WRITE, 10'd0, m, fb[0], 9'(base + off),
							8'($urandom), (i == nw - 1) && ($urandom_range(0, 9) != 0), r);
					end
				end
			end else if (sel < 64) begin
				add_item(ppbuf_pkg::ACT_POLL, 10'($urandom_range(0, 512)), 16'($urandom),
					1'($urandom), 9'($urandom), 8'($urandom), 1'($urandom), r);
			end else if (sel < 72) begin
				add_item(ppbuf_pkg::ACT_COMPLETE, 10'($urandom_range(0, 512)), 16'($urandom),
					1'($urandom), 9'($urandom), 8'($urandom), 1'($urandom), r);
			end else if (sel < 84) begin
				if (written_q.size() > 0)
					add_read();
			end else if (sel < 89) begin
				fb = $urandom_range(0, 1);
				add_item(ppbuf_pkg::ACT_WRITE, 10'd0, plan_state.wmask[fb], fb[0],
					9'($urandom), 8'($urandom), 1'b1, r);
			end else begin
				act = 3'($urandom_range(0, 7));
				if (act == ppbuf_pkg::ACT_READ && written_q.size() > 0)
					add_read();
				else
					add_item((act == ppbuf_pkg::ACT_READ) ? ppbuf_pkg::ACT_POLL : act,
						10'($urandom_range(0, 512)), 16'($urandom), 1'($urandom),
						9'($urandom), 8'($urandom), 1'($urandom), r);
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, int seen, int want);
		if (seen != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, seen, want));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || took)) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				cur_item <= pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin : monitor
		ppbuf_pkg::out_item_t want;
		ppbuf_pkg::out_item_t seen;
		bit got;
		took = arst_n && s_axis_tvalid && s_axis_tready;
		got = arst_n && m_axis_tvalid && m_axis_tready;
		if (took) begin
			advance_buffer(dut_view, cur_item, want);
			expected_results.push_back(want);
		end
		if (got) begin
			seen = ppbuf_pkg::out_item_t'(m_axis_tdata[ppbuf_pkg::OUT_ITEM_BITS-1:0]);
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("item %h with nothing expected", m_axis_tdata));
			end else begin
				want = expected_results.pop_front();
				check_field("status", int'(seen.status), int'(want.status));
				check_field("start_index", int'(seen.start_index), int'(want.start_index));
				check_field("start_transmit", int'(seen.start_transmit),
					int'(want.start_transmit));
				check_field("transmit_bank", int'(seen.transmit_bank),
					int'(want.transmit_bank));
				check_field("transmit_length", int'(seen.transmit_length),
					int'(want.transmit_length));
				check_field("trigger_state", int'(seen.trigger_state),
					int'(want.trigger_state));
				check_field("read_data", int'(seen.read_data), int'(want.read_data));
			end
		end
		quiet_cycles = (took || got) ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		ppbuf_pkg::out_item_t r;
		arst_n = 1'b0;
		plan_state = reset_state();
		dut_view = reset_state();
		send_idle = 9;
		recv_idle = 88;

		// empty poll, full bank, clash, last free byte, writers holding a closed bank
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd512, 16'h0001, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd511, 16'h8000, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd0, 16'h8000, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd0, 16'h0001, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_WRITE, 10'd0, 16'h8000, 1'b0, 9'd0, 8'hFF, 1'b0, r);
		add_item(ppbuf_pkg::ACT_WRITE, 10'd0, 16'h0001, 1'b0, 9'd511, 8'h00, 1'b1, r);
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd5, 16'hFFFF, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_WRITE, 10'd0, 16'h8000, 1'b0, 9'd1, 8'hA5, 1'b1, r);
		add_item(ppbuf_pkg::ACT_READ, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_READ, 10'd0, 16'd0, 1'b0, 9'd511, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_COMPLETE, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_WRITE, 10'd0, 16'hFFFF, 1'b1, 9'd4, 8'h5A, 1'b1, r);
		add_item(ppbuf_pkg::ACT_POLL, 10'd0, 16'd0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		add_item(ppbuf_pkg::ACT_RESERVE, 10'd3, 16'h00F0, 1'b0, 9'd0, 8'd0, 1'b0, r);
		for (int a = int'(ppbuf_pkg::ACT_READ) + 1; a < 8; a++)
			add_item(3'(a), 10'($urandom_range(0, 512)), 16'($urandom), 1'($urandom),
				9'($urandom), 8'($urandom), 1'($urandom), r);
		add_item(ppbuf_pkg::ACT_READ, 10'd0, 16'd0, 1'b1, 9'd4, 8'd0, 1'b0, r);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		gen_traffic(175);
		drain();
		send_idle = 88;
		recv_idle = 9;
		gen_traffic(175);
		drain();
		send_idle = 0;
		recv_idle = 0;
		gen_traffic(175);
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
